[design/rci_pkg.sv]
// Shared types, codes and helpers for the ray / cylinder intersection core.
package rci_pkg;

    localparam int MAG_W   = 32;
    localparam int PROD_W  = 64;
    localparam int WIDE_W  = 128;
    localparam int ROOT_W  = 64;
    localparam int T_W     = 31;
    localparam int ST_W    = 3;
    localparam int CFG_W   = 31;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 1'b1;

    localparam logic [T_W-1:0] T_SAT = {T_W{1'b1}};

    typedef enum logic [ST_W-1:0] {
        ST_HIT      = 3'd0,
        ST_NEG_DISC = 3'd1,
        ST_BOTH_NEG = 3'd2,
        ST_LIN_NEG  = 3'd3,
        ST_ZERO_B   = 3'd4
    } status_t;

    // sign and magnitude value
    typedef struct packed {
        logic [PROD_W-1:0] mag;
        logic              neg;
    } smag_t;

    // quadratic terms: A, B/2 and C
    typedef struct packed {
        logic [PROD_W-1:0] am;
        logic [PROD_W-1:0] bm;
        logic              bs;
        logic [PROD_W-1:0] cm;
        logic              cs;
        logic              quad;
    } terms_t;

    // what travels beside the square root
    typedef struct packed {
        logic              quad;
        status_t           status;
        logic              bs;
        logic [PROD_W-1:0] num_src;
        logic [PROD_W-1:0] den;
    } side_t;

    function automatic smag_t sm_add(input logic [PROD_W-1:0] m1, input logic s1,
                                     input logic [PROD_W-1:0] m2, input logic s2);
        smag_t r;
        if (s1 == s2)
        begin
            r.mag = m1 + m2;
            r.neg = s1;
        end
        else if (m1 >= m2)
        begin
            r.mag = m1 - m2;
            r.neg = s1;
        end
        else
        begin
            r.mag = m2 - m1;
            r.neg = s2;
        end
        if (r.mag == '0)
            r.neg = 1'b0;
        return r;
    endfunction

endpackage

[design/rci_terms.sv]
// Forms the A, B/2 and C terms of the intersection quadratic over four stages.
module rci_terms #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic signed [31:0]           start_x,
    input  logic signed [31:0]           start_y,
    input  logic signed [31:0]           dir_x,
    input  logic signed [31:0]           dir_y,
    input  logic [rci_pkg::CFG_W-1:0]    radius,
    input  logic [rci_pkg::CFG_W-1:0]    thresh,
    output logic                         out_valid,
    output rci_pkg::terms_t              terms
);
    import rci_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg;

    // stage 1: magnitudes and signs
    logic [MAG_W-1:0] mx_reg, my_reg, mdx_reg, mdy_reg;
    logic [MAG_W-1:0] mx_next, my_next, mdx_next, mdy_next;
    logic nx_reg, ny_reg, ndx_reg, ndy_reg;

    // stage 2: products
    logic [PROD_W-1:0] pxx_reg, pyy_reg, pdx_reg, pdy_reg, pb1_reg, pb2_reg, rr_reg;
    logic sb1_reg, sb2_reg;

    // stage 3: partial sums
    logic [PROD_W-1:0] am3_reg, c1_reg, rr3_reg;
    smag_t b3_reg, b3_next;

    // stage 4
    terms_t t4_reg, t4_next;
    logic [PROD_W-1:0] thresh_sh;
    smag_t c4;

    always_comb
    begin
        mx_next  = start_x[31] ? (~start_x + 32'd1) : start_x;
        my_next  = start_y[31] ? (~start_y + 32'd1) : start_y;
        mdx_next = dir_x[31]   ? (~dir_x + 32'd1)   : dir_x;
        mdy_next = dir_y[31]   ? (~dir_y + 32'd1)   : dir_y;
    end

    assign b3_next   = sm_add(pb1_reg, sb1_reg, pb2_reg, sb2_reg);
    assign thresh_sh = {{(PROD_W-CFG_W){1'b0}}, thresh} << FRAC_BITS;
    assign c4        = sm_add(c1_reg, 1'b0, rr3_reg, 1'b1);

    always_comb
    begin
        t4_next.am   = am3_reg;
        t4_next.bm   = b3_reg.mag;
        t4_next.bs   = b3_reg.neg;
        t4_next.cm   = c4.mag;
        t4_next.cs   = c4.neg;
        t4_next.quad = am3_reg > thresh_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg  <= mx_next;
            my_reg  <= my_next;
            mdx_reg <= mdx_next;
            mdy_reg <= mdy_next;
            nx_reg  <= start_x[31];
            ny_reg  <= start_y[31];
            ndx_reg <= dir_x[31];
            ndy_reg <= dir_y[31];

            pxx_reg <= mx_reg * mx_reg;
            pyy_reg <= my_reg * my_reg;
            pdx_reg <= mdx_reg * mdx_reg;
            pdy_reg <= mdy_reg * mdy_reg;
            pb1_reg <= mx_reg * mdx_reg;
            pb2_reg <= my_reg * mdy_reg;
            rr_reg  <= {1'b0, radius} * {1'b0, radius};
            sb1_reg <= nx_reg ^ ndx_reg;
            sb2_reg <= ny_reg ^ ndy_reg;

            am3_reg <= pdx_reg + pdy_reg;
            c1_reg  <= pxx_reg + pyy_reg;
            rr3_reg <= rr_reg;
            b3_reg  <= b3_next;

            t4_reg  <= t4_next;
        end
    end

    assign out_valid = v4_reg;
    assign terms     = t4_reg;

endmodule

[design/rci_disc.sv]
// Wide products B^2/4 and A*C from 32x32 partials, then the quarter discriminant.
module rci_disc (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  rci_pkg::terms_t               terms,
    output logic                          out_valid,
    output logic [rci_pkg::WIDE_W-1:0]    disc,
    output rci_pkg::side_t                side
);
    import rci_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    terms_t t1_reg, t2_reg, t3_reg;

    // stage 1: partial products
    logic [PROD_W-1:0] bb00_reg, bb01_reg, bb11_reg;
    logic [PROD_W-1:0] ac00_reg, ac01_reg, ac10_reg, ac11_reg;

    // stage 2: cross sums
    logic [PROD_W-1:0] bb00_2_reg, bb11_2_reg, ac00_2_reg, ac11_2_reg;
    logic [PROD_W:0]   bx_reg, ax_reg;

    // stage 3: full products
    logic [WIDE_W-1:0] b2_reg, ac_reg;

    // stage 4
    logic [WIDE_W-1:0] d_reg, d_next;
    side_t side_reg, side_next;

    always_comb
    begin
        d_next            = '0;
        side_next.quad    = t3_reg.quad;
        side_next.bs      = t3_reg.bs;
        side_next.num_src = t3_reg.quad ? t3_reg.bm : t3_reg.cm;
        side_next.den     = t3_reg.quad ? t3_reg.am : t3_reg.bm;
        side_next.status  = ST_HIT;
        if (t3_reg.quad)
        begin
            if (t3_reg.cs)
                d_next = b2_reg + ac_reg;
            else if (b2_reg < ac_reg)
                side_next.status = ST_NEG_DISC;
            else
                d_next = b2_reg - ac_reg;
        end
        else if (t3_reg.bm == '0)
            side_next.status = ST_ZERO_B;
        else if (t3_reg.cm != '0 && t3_reg.cs == t3_reg.bs)
            side_next.status = ST_LIN_NEG;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg   <= terms;
            bb00_reg <= terms.bm[31:0]  * terms.bm[31:0];
            bb01_reg <= terms.bm[31:0]  * terms.bm[63:32];
            bb11_reg <= terms.bm[63:32] * terms.bm[63:32];
            ac00_reg <= terms.am[31:0]  * terms.cm[31:0];
            ac01_reg <= terms.am[31:0]  * terms.cm[63:32];
            ac10_reg <= terms.am[63:32] * terms.cm[31:0];
            ac11_reg <= terms.am[63:32] * terms.cm[63:32];

            t2_reg     <= t1_reg;
            bb00_2_reg <= bb00_reg;
            bb11_2_reg <= bb11_reg;
            ac00_2_reg <= ac00_reg;
            ac11_2_reg <= ac11_reg;
            bx_reg     <= {bb01_reg, 1'b0};
            ax_reg     <= {1'b0, ac01_reg} + {1'b0, ac10_reg};

            t3_reg <= t2_reg;
            b2_reg <= {bb11_2_reg, bb00_2_reg} + ({{(WIDE_W-PROD_W-1){1'b0}}, bx_reg} << 32);
            ac_reg <= {ac11_2_reg, ac00_2_reg} + ({{(WIDE_W-PROD_W-1){1'b0}}, ax_reg} << 32);

            d_reg    <= d_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = v4_reg;
    assign disc      = d_reg;
    assign side      = side_reg;

endmodule

[design/rci_isqrt.sv]
// Floor square root of a 128-bit value, one root bit per pipeline stage.
module rci_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [rci_pkg::WIDE_W-1:0]    radicand,
    input  rci_pkg::side_t                side_in,
    output logic                          out_valid,
    output logic [rci_pkg::ROOT_W-1:0]    root,
    output rci_pkg::side_t                side_out
);
    import rci_pkg::*;

    localparam int REM_W = ROOT_W + 4;

    logic              v_reg    [0:ROOT_W-1];
    logic [REM_W-1:0]  rem_reg  [0:ROOT_W-1];
    logic [ROOT_W-1:0] root_reg [0:ROOT_W-1];
    logic [WIDE_W-1:0] val_reg  [0:ROOT_W-1];
    side_t             side_reg [0:ROOT_W-1];

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++)
        begin : g_stage
            logic              cur_v;
            logic [REM_W-1:0]  cur_rem;
            logic [ROOT_W-1:0] cur_root;
            logic [WIDE_W-1:0] cur_val;
            side_t             cur_side;
            logic [REM_W-1:0]  rem_sh;
            logic [REM_W-1:0]  trial;
            logic              ge;

            if (k == 0)
            begin : g_first
                assign cur_v    = in_valid;
                assign cur_rem  = '0;
                assign cur_root = '0;
                assign cur_val  = radicand;
                assign cur_side = side_in;
            end
            else
            begin : g_next
                assign cur_v    = v_reg[k-1];
                assign cur_rem  = rem_reg[k-1];
                assign cur_root = root_reg[k-1];
                assign cur_val  = val_reg[k-1];
                assign cur_side = side_reg[k-1];
            end

            // bring down two radicand bits, try root*4+1
            assign rem_sh = {cur_rem[REM_W-3:0], cur_val[WIDE_W-1 -: 2]};
            assign trial  = {2'b00, cur_root, 2'b01};
            assign ge     = rem_sh >= trial;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[k] <= 1'b0;
                else if (en)
                    v_reg[k] <= cur_v;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= ge ? (rem_sh - trial) : rem_sh;
                    root_reg[k] <= {cur_root[ROOT_W-2:0], ge};
                    val_reg[k]  <= {cur_val[WIDE_W-3:0], 2'b00};
                    side_reg[k] <= cur_side;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign side_out  = side_reg[ROOT_W-1];

endmodule

[design/rci_div.sv]
// Root selection, then a saturating restoring divide, one quotient bit per stage.
module rci_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [rci_pkg::ROOT_W-1:0]   root,
    input  rci_pkg::side_t               side,
    output logic                         out_valid,
    output rci_pkg::status_t             status,
    output logic [rci_pkg::T_W-1:0]      ray_param
);
    import rci_pkg::*;

    localparam int NUM_W = PROD_W + 1;
    localparam int DVW   = NUM_W + FRAC_BITS;
    localparam int HW    = DVW - T_W;

    // stage R: numerator and dividend
    logic              vr_reg;
    logic [DVW-1:0]    dvd_reg, dvd_next;
    logic [PROD_W-1:0] denr_reg;
    status_t           str_reg, str_next;
    logic [NUM_W-1:0]  num;

    // stage S: saturation check
    logic              vs_reg;
    logic              sat_reg;
    logic [PROD_W-1:0] rems_reg, dens_reg;
    logic [T_W-1:0]    lows_reg;
    status_t           sts_reg;
    logic [HW-1:0]     hi;

    // quotient stages
    logic              vq_reg   [0:T_W-1];
    logic              satq_reg [0:T_W-1];
    logic [PROD_W-1:0] remq_reg [0:T_W-1];
    logic [PROD_W-1:0] denq_reg [0:T_W-1];
    logic [T_W-1:0]    lowq_reg [0:T_W-1];
    logic [T_W-1:0]    q_reg    [0:T_W-1];
    status_t           stq_reg  [0:T_W-1];

    always_comb
    begin
        num      = '0;
        str_next = side.status;
        if (side.quad && side.status == ST_HIT)
        begin
            if (side.bs && side.num_src >= root)
                num = {1'b0, side.num_src - root};
            else if (side.bs)
                num = {1'b0, side.num_src} + {1'b0, root};
            else if (root >= side.num_src)
                num = {1'b0, root - side.num_src};
            else
                str_next = ST_BOTH_NEG;
        end
        if (side.quad)
            dvd_next = {{FRAC_BITS{1'b0}}, num} << FRAC_BITS;
        else
            dvd_next = {{FRAC_BITS{1'b0}}, 1'b0, side.num_src} << (FRAC_BITS - 1);
    end

    assign hi = dvd_reg[DVW-1:T_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vr_reg <= 1'b0;
            vs_reg <= 1'b0;
        end
        else if (en)
        begin
            vr_reg <= in_valid;
            vs_reg <= vr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dvd_reg  <= dvd_next;
            denr_reg <= side.den;
            str_reg  <= str_next;

            sat_reg  <= PROD_W'(hi) >= denr_reg;
            rems_reg <= PROD_W'(hi);
            lows_reg <= dvd_reg[T_W-1:0];
            dens_reg <= denr_reg;
            sts_reg  <= str_reg;
        end
    end

    genvar j;
    generate
        for (j = 0; j < T_W; j++)
        begin : g_qbit
            logic              cur_v, cur_sat;
            logic [PROD_W-1:0] cur_rem, cur_den;
            logic [T_W-1:0]    cur_low, cur_q;
            status_t           cur_st;
            logic [PROD_W:0]   rem_sh;
            logic              ge;

            if (j == 0)
            begin : g_first
                assign cur_v   = vs_reg;
                assign cur_sat = sat_reg;
                assign cur_rem = rems_reg;
                assign cur_den = dens_reg;
                assign cur_low = lows_reg;
                assign cur_q   = '0;
                assign cur_st  = sts_reg;
            end
            else
            begin : g_next
                assign cur_v   = vq_reg[j-1];
                assign cur_sat = satq_reg[j-1];
                assign cur_rem = remq_reg[j-1];
                assign cur_den = denq_reg[j-1];
                assign cur_low = lowq_reg[j-1];
                assign cur_q   = q_reg[j-1];
                assign cur_st  = stq_reg[j-1];
            end

            assign rem_sh = {cur_rem, cur_low[T_W-1]};
            assign ge     = rem_sh >= {1'b0, cur_den};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vq_reg[j] <= 1'b0;
                else if (en)
                    vq_reg[j] <= cur_v;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    remq_reg[j] <= ge ? PROD_W'(rem_sh - {1'b0, cur_den}) : PROD_W'(rem_sh);
                    q_reg[j]    <= {cur_q[T_W-2:0], ge};
                    lowq_reg[j] <= {cur_low[T_W-2:0], 1'b0};
                    denq_reg[j] <= cur_den;
                    satq_reg[j] <= cur_sat;
                    stq_reg[j]  <= cur_st;
                end
            end
        end
    endgenerate

    assign out_valid = vq_reg[T_W-1];
    assign status    = stq_reg[T_W-1];
    assign ray_param = satq_reg[T_W-1] ? T_SAT : q_reg[T_W-1];

endmodule

[design/ray_cylinder_intersection_core.sv]
// Top level: ray versus infinite Z-axis cylinder intersection core.
// Accepts one ray per clock while s_axis_tready is high and returns one result per
// ray, in order. The pipeline holds 4 stages that form A, B/2 and C, 4 that build
// the 128-bit discriminant from 32x32 partial products, 64 that extract the square
// root one bit each, 33 that select the root and run the divide one quotient bit
// each, and one output register. The whole pipeline advances together; a
// one-entry skid stage behind the output register absorbs a stall, so
// s_axis_tready is a registered signal. Configuration writes take effect at once
// and must be issued only while no ray is in flight.
module ray_cylinder_intersection_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [31:0] start_x, [63:32] start_y, [95:64] dir_x, [127:96] dir_y
    input  logic [127:0]                      s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] hit, [31:1] ray_param, [34:32] status, [39:35] zero
    output logic [39:0]                       m_axis_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rci_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rci_pkg::CFG_W-1:0]         cfg_data
);
    import rci_pkg::*;

    logic [CFG_W-1:0] radius_reg, thresh_reg;
    logic             en;

    logic              terms_valid;
    terms_t            terms;
    logic              disc_valid;
    logic [WIDE_W-1:0] disc;
    side_t             disc_side;
    logic              sq_valid;
    logic [ROOT_W-1:0] root;
    side_t             sq_side;
    logic              res_valid;
    status_t           res_status;
    logic [T_W-1:0]    res_t;
    logic [39:0]       res_data;

    logic        out_valid_reg, skid_valid_reg;
    logic [39:0] out_data_reg, skid_data_reg;
    logic        pop, arrive;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 31'd65536;
            thresh_reg <= 31'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RADIUS: radius_reg <= cfg_data;
                CFG_THRESH: thresh_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // hold the whole pipeline while the skid stage is occupied
    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    rci_terms #(.FRAC_BITS(FRAC_BITS)) u_terms (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .start_x   (s_axis_tdata[31:0]),
        .start_y   (s_axis_tdata[63:32]),
        .dir_x     (s_axis_tdata[95:64]),
        .dir_y     (s_axis_tdata[127:96]),
        .radius    (radius_reg),
        .thresh    (thresh_reg),
        .out_valid (terms_valid),
        .terms     (terms)
    );

    rci_disc u_disc (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (terms_valid),
        .terms     (terms),
        .out_valid (disc_valid),
        .disc      (disc),
        .side      (disc_side)
    );

    rci_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (disc_valid),
        .radicand  (disc),
        .side_in   (disc_side),
        .out_valid (sq_valid),
        .root      (root),
        .side_out  (sq_side)
    );

    rci_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .root      (root),
        .side      (sq_side),
        .out_valid (res_valid),
        .status    (res_status),
        .ray_param (res_t)
    );

    always_comb
    begin
        res_data        = '0;
        res_data[0]     = (res_status == ST_HIT);
        res_data[31:1]  = (res_status == ST_HIT) ? res_t : '0;
        res_data[34:32] = res_status;
    end

    assign pop    = out_valid_reg && m_axis_tready;
    assign arrive = res_valid && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || pop)
            out_valid_reg <= arrive;
        else if (arrive)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_data_reg <= skid_data_reg;
        end
        else if (!out_valid_reg || pop)
            out_data_reg <= res_data;
        else if (arrive)
            skid_data_reg <= res_data;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("skid stage full while output register empty");

    a_hit_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[34:32] == ST_HIT)))
        else $error("hit flag disagrees with status");

    a_miss_zero_param: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[31:1] == '0))
        else $error("ray_param nonzero on a miss");

endmodule
